>>> rtl/seh_pkg.sv
// shared types, constants and helpers for the substring equality hash block
package seh_pkg;

    localparam int MAX_LEN = 1024;
    localparam int LEN_W   = 11;
    localparam int POS_W   = 10;
    localparam int HASH_W  = 30;
    localparam int CHAR_W  = 8;
    localparam int STEP_W  = 5;

    localparam logic [STEP_W-1:0] MUL_STEPS  = STEP_W'(HASH_W);
    localparam logic [HASH_W-1:0] MOD_FIRST  = 30'd1000000007;
    localparam logic [HASH_W-1:0] MOD_SECOND = 30'd1000000009;
    localparam logic [HASH_W-1:0] BASE_RESET = 30'd11;
    localparam logic [LEN_W-1:0]  LEN_FULL   = LEN_W'(MAX_LEN);

    typedef enum logic [1:0] {
        REQ_APPEND = 2'd0,
        REQ_QUERY  = 2'd1,
        REQ_CLEAR  = 2'd2,
        REQ_NONE   = 2'd3
    } req_t;

    typedef struct packed {
        logic [1:0]        req_type;
        logic [CHAR_W-1:0] text_char;
        logic [POS_W-1:0]  pos_a;
        logic [POS_W-1:0]  pos_b;
        logic [LEN_W-1:0]  sub_len;
    } in_item_t;

    typedef struct packed {
        logic equal;
        logic hash_match;
        logic range_error;
    } out_item_t;

    typedef struct packed {
        logic [HASH_W-1:0] pf;
        logic [HASH_W-1:0] ps;
        logic [HASH_W-1:0] qf;
        logic [HASH_W-1:0] qs;
    } hash_entry_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_A_RD,
        S_A_GO,
        S_A_MUL,
        S_Q_LEN,
        S_Q_A,
        S_Q_B,
        S_Q_AE,
        S_Q_BE,
        S_Q_MUL,
        S_C_RD,
        S_C_CHK,
        S_OUT
    } state_t;

    // (p - t) mod m with p, t already below m
    function automatic logic [HASH_W-1:0] sub_mod(input logic [HASH_W-1:0] p,
                                                  input logic [HASH_W-1:0] t,
                                                  input logic [HASH_W-1:0] m);
        logic [HASH_W:0] r;
        r = {1'b0, p} + {1'b0, m} - {1'b0, t};
        if (r >= {1'b0, m})
        begin
            r = r - {1'b0, m};
        end
        return r[HASH_W-1:0];
    endfunction

endpackage

>>> rtl/seh_mulmod.sv
// bit-serial modular multiply-add, one multiplier bit per cycle, msb first
module seh_mulmod
    import seh_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [HASH_W-1:0] x,
    input  logic [HASH_W-1:0] y,
    input  logic [CHAR_W-1:0] addend,
    input  logic [HASH_W-1:0] modulus,
    output logic              done,
    output logic [HASH_W-1:0] result
);

    logic              active_reg;
    logic              done_reg;
    logic [STEP_W-1:0] cnt_reg;
    logic [HASH_W-1:0] acc_reg;
    logic [HASH_W-1:0] x_reg;
    logic [HASH_W-1:0] y_reg;
    logic [CHAR_W-1:0] add_reg;
    logic [HASH_W-1:0] acc_next;
    logic [HASH_W:0]   dbl;
    logic [HASH_W:0]   dbl_red;
    logic [HASH_W:0]   sum;
    logic [HASH_W:0]   fin;
    logic [HASH_W:0]   mod_ext;

    always_comb
    begin
        mod_ext = {1'b0, modulus};
        dbl     = {acc_reg, 1'b0};
        dbl_red = (dbl >= mod_ext) ? dbl - mod_ext : dbl;
        sum     = dbl_red + (y_reg[HASH_W-1] ? {1'b0, x_reg} : '0);
        if (sum >= mod_ext)
        begin
            sum = sum - mod_ext;
        end
        fin = {1'b0, acc_reg} + {{(HASH_W+1-CHAR_W){1'b0}}, add_reg};
        if (fin >= mod_ext)
        begin
            fin = fin - mod_ext;
        end
        acc_next = (cnt_reg != '0) ? sum[HASH_W-1:0] : fin[HASH_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= 1'b0;
            done_reg   <= 1'b0;
            cnt_reg    <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                active_reg <= 1'b1;
                cnt_reg    <= MUL_STEPS;
            end
            else if (active_reg)
            begin
                if (cnt_reg != '0)
                begin
                    cnt_reg <= cnt_reg - 1'b1;
                end
                else
                begin
                    active_reg <= 1'b0;
                    done_reg   <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            acc_reg <= '0;
            x_reg   <= x;
            y_reg   <= y;
            add_reg <= addend;
        end
        else if (active_reg)
        begin
            acc_reg <= acc_next;
            y_reg   <= {y_reg[HASH_W-2:0], 1'b0};
        end
    end

    assign done   = done_reg;
    assign result = acc_reg;

endmodule

>>> rtl/seh_hash_mem.sv
// prefix-hash and base-power tables, one write and one registered read port
module seh_hash_mem
    import seh_pkg::*;
(
    input  logic             clk,
    input  logic [LEN_W-1:0] rd_addr,
    input  logic             wr_en,
    input  logic [LEN_W-1:0] wr_addr,
    input  hash_entry_t      wr_data,
    output hash_entry_t      rd_data
);

    hash_entry_t mem [0:MAX_LEN];
    hash_entry_t q_reg;
    logic        zero_reg;
    hash_entry_t zero_entry;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        q_reg    <= mem[rd_addr];
        zero_reg <= (rd_addr == '0);
    end

    // entry zero is fixed: empty prefix hash, unit power
    always_comb
    begin
        zero_entry.pf = '0;
        zero_entry.ps = '0;
        zero_entry.qf = HASH_W'(1);
        zero_entry.qs = HASH_W'(1);
        rd_data = zero_reg ? zero_entry : q_reg;
    end

endmodule

>>> rtl/seh_text_mem.sv
// character store, one write port and two registered read ports
module seh_text_mem
    import seh_pkg::*;
(
    input  logic              clk,
    input  logic              wr_en,
    input  logic [POS_W-1:0]  wr_addr,
    input  logic [CHAR_W-1:0] wr_data,
    input  logic [POS_W-1:0]  rd_addr_a,
    input  logic [POS_W-1:0]  rd_addr_b,
    output logic [CHAR_W-1:0] rd_data_a,
    output logic [CHAR_W-1:0] rd_data_b
);

    logic [CHAR_W-1:0] mem [0:MAX_LEN-1];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_a <= mem[rd_addr_a];
        rd_data_b <= mem[rd_addr_b];
    end

endmodule

>>> rtl/substring_equality_hash.sv
// top level: double rolling hash substring equality engine
//
// channel   | handshake                    | beat
// ----------+------------------------------+--------------------------------
// in        | in_valid / in_stall          | in_item_t: request and operands
// out       | out_valid / out_stall        | out_item_t: one per query
// cfg       | cfg_valid / cfg_ready        | cfg_data: hash base
//
// one request at a time; in_stall is high while a request is in flight
// append: one pass of the four bit-serial multipliers
// query: a hash pass of the four multipliers, then a character-by-character check
//   when the hashes agree; a range error answers without the hash pass
// clear and unused request codes give no beat
// rst_n clears control state and reloads the base; tables need no clearing pass
// a finished beat waits in the output register while out_stall is high
module substring_equality_hash
    import seh_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  in_item_t          in_data,
    output logic              out_valid,
    input  logic              out_stall,
    output out_item_t         out_data,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [HASH_W-1:0] cfg_data
);

    state_t            state_reg;
    state_t            state_next;
    logic [HASH_W-1:0] base_reg;
    logic [LEN_W-1:0]  len_reg;
    in_item_t          req_reg;
    logic [HASH_W-1:0] yf_reg;
    logic [HASH_W-1:0] ys_reg;
    logic [HASH_W-1:0] xaf_reg;
    logic [HASH_W-1:0] xas_reg;
    logic [HASH_W-1:0] xbf_reg;
    logic [HASH_W-1:0] xbs_reg;
    logic [HASH_W-1:0] eaf_reg;
    logic [HASH_W-1:0] eas_reg;
    logic [LEN_W-1:0]  cnt_reg;
    out_item_t         res_reg;
    logic              out_valid_reg;
    out_item_t         out_data_reg;

    logic              in_acc;
    logic              range_bad;
    logic [LEN_W-1:0]  a_end;
    logic [LEN_W-1:0]  b_end;
    logic [LEN_W-1:0]  hash_rd_addr;
    hash_entry_t       hash_rd;
    hash_entry_t       hash_wr;
    logic              hash_we;
    logic              text_we;
    logic              mul_start;
    logic              is_append;
    logic [HASH_W-1:0] mx [0:3];
    logic [HASH_W-1:0] mr [0:3];
    logic [CHAR_W-1:0] madd;
    logic              mdone [0:3];
    logic              hm;
    logic [POS_W-1:0]  ta_addr;
    logic [POS_W-1:0]  tb_addr;
    logic [CHAR_W-1:0] ta_data;
    logic [CHAR_W-1:0] tb_data;
    logic              out_load;
    logic              cmp_last;

    assign in_stall  = (state_reg != S_IDLE);
    assign cfg_ready = 1'b1;
    assign in_acc    = in_valid && !in_stall;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    // range check on the live beat, ends kept from the captured beat
    always_comb
    begin
        logic [LEN_W:0] ea;
        logic [LEN_W:0] eb;
        logic [LEN_W:0] sa;
        logic [LEN_W:0] sb;
        ea = {2'b00, in_data.pos_a} + {1'b0, in_data.sub_len};
        eb = {2'b00, in_data.pos_b} + {1'b0, in_data.sub_len};
        range_bad = (ea > {1'b0, len_reg}) || (eb > {1'b0, len_reg});
        sa = {2'b00, req_reg.pos_a} + {1'b0, req_reg.sub_len};
        sb = {2'b00, req_reg.pos_b} + {1'b0, req_reg.sub_len};
        a_end = sa[LEN_W-1:0];
        b_end = sb[LEN_W-1:0];
    end

    assign is_append = (state_reg == S_A_GO);
    assign mx[0] = is_append ? hash_rd.pf : xaf_reg;
    assign mx[1] = is_append ? hash_rd.qf : xbf_reg;
    assign mx[2] = is_append ? hash_rd.ps : xas_reg;
    assign mx[3] = is_append ? hash_rd.qs : xbs_reg;
    assign madd  = is_append ? req_reg.text_char : '0;

    seh_mulmod u_mul_pf (
        .clk(clk), .rst_n(rst_n), .start(mul_start), .x(mx[0]),
        .y(is_append ? base_reg : yf_reg), .addend(madd), .modulus(MOD_FIRST),
        .done(mdone[0]), .result(mr[0])
    );

    seh_mulmod u_mul_qf (
        .clk(clk), .rst_n(rst_n), .start(mul_start), .x(mx[1]),
        .y(is_append ? base_reg : yf_reg), .addend('0), .modulus(MOD_FIRST),
        .done(mdone[1]), .result(mr[1])
    );

    seh_mulmod u_mul_ps (
        .clk(clk), .rst_n(rst_n), .start(mul_start), .x(mx[2]),
        .y(is_append ? base_reg : ys_reg), .addend(madd), .modulus(MOD_SECOND),
        .done(mdone[2]), .result(mr[2])
    );

    seh_mulmod u_mul_qs (
        .clk(clk), .rst_n(rst_n), .start(mul_start), .x(mx[3]),
        .y(is_append ? base_reg : ys_reg), .addend('0), .modulus(MOD_SECOND),
        .done(mdone[3]), .result(mr[3])
    );

    // in a query the units hold pre[start] * pw[len] for a then b
    always_comb
    begin
        hm = (sub_mod(eaf_reg, mr[0], MOD_FIRST) == sub_mod(hash_rd.pf, mr[1], MOD_FIRST))
          && (sub_mod(eas_reg, mr[2], MOD_SECOND) == sub_mod(hash_rd.ps, mr[3], MOD_SECOND));
    end

    assign hash_wr.pf = mr[0];
    assign hash_wr.qf = mr[1];
    assign hash_wr.ps = mr[2];
    assign hash_wr.qs = mr[3];

    seh_hash_mem u_hash_mem (
        .clk(clk), .rd_addr(hash_rd_addr), .wr_en(hash_we),
        .wr_addr(len_reg + 1'b1), .wr_data(hash_wr), .rd_data(hash_rd)
    );

    assign ta_addr = req_reg.pos_a + cnt_reg[POS_W-1:0];
    assign tb_addr = req_reg.pos_b + cnt_reg[POS_W-1:0];

    seh_text_mem u_text_mem (
        .clk(clk), .wr_en(text_we), .wr_addr(len_reg[POS_W-1:0]),
        .wr_data(req_reg.text_char), .rd_addr_a(ta_addr), .rd_addr_b(tb_addr),
        .rd_data_a(ta_data), .rd_data_b(tb_data)
    );

    assign cmp_last = ((cnt_reg + 1'b1) == req_reg.sub_len);
    assign out_load = (state_reg == S_OUT) && (!out_valid_reg || !out_stall);

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_acc)
                begin
                    case (req_t'(in_data.req_type))
                        REQ_APPEND: state_next = (len_reg != LEN_FULL) ? S_A_RD : S_IDLE;
                        REQ_QUERY:  state_next = range_bad ? S_OUT : S_Q_LEN;
                        default:    state_next = S_IDLE;
                    endcase
                end
            end
            S_A_RD:  state_next = S_A_GO;
            S_A_GO:  state_next = S_A_MUL;
            S_A_MUL: state_next = mdone[0] ? S_IDLE : S_A_MUL;
            S_Q_LEN: state_next = S_Q_A;
            S_Q_A:   state_next = S_Q_B;
            S_Q_B:   state_next = S_Q_AE;
            S_Q_AE:  state_next = S_Q_BE;
            S_Q_BE:  state_next = S_Q_MUL;
            S_Q_MUL:
            begin
                if (mdone[0])
                begin
                    state_next = (hm && req_reg.sub_len != '0) ? S_C_RD : S_OUT;
                end
            end
            S_C_RD:  state_next = S_C_CHK;
            S_C_CHK: state_next = (ta_data != tb_data || cmp_last) ? S_OUT : S_C_RD;
            S_OUT:   state_next = out_load ? S_IDLE : S_OUT;
            default: state_next = S_IDLE;
        endcase
    end

    // control outputs
    always_comb
    begin
        hash_rd_addr = len_reg;
        hash_we      = 1'b0;
        text_we      = 1'b0;
        mul_start    = 1'b0;
        case (state_reg)
            S_A_RD:  hash_rd_addr = len_reg;
            S_A_GO:
            begin
                hash_rd_addr = len_reg;
                mul_start    = 1'b1;
            end
            S_A_MUL:
            begin
                hash_we = mdone[0];
                text_we = mdone[0];
            end
            S_Q_LEN: hash_rd_addr = req_reg.sub_len;
            S_Q_A:   hash_rd_addr = {1'b0, req_reg.pos_a};
            S_Q_B:   hash_rd_addr = {1'b0, req_reg.pos_b};
            S_Q_AE:  hash_rd_addr = a_end;
            S_Q_BE:
            begin
                hash_rd_addr = b_end;
                mul_start    = 1'b1;
            end
            S_Q_MUL: hash_rd_addr = b_end;
            default: hash_rd_addr = len_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            base_reg      <= BASE_RESET;
            len_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_valid && cfg_ready)
            begin
                base_reg <= cfg_data;
            end
            if (in_acc && req_t'(in_data.req_type) == REQ_CLEAR)
            begin
                len_reg <= '0;
            end
            else if (hash_we)
            begin
                len_reg <= len_reg + 1'b1;
            end
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // operand capture as table reads come back
    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            req_reg <= in_data;
            res_reg <= '{equal: 1'b0, hash_match: 1'b0, range_error: 1'b1};
        end
        case (state_reg)
            S_Q_A:
            begin
                yf_reg <= hash_rd.qf;
                ys_reg <= hash_rd.qs;
            end
            S_Q_B:
            begin
                xaf_reg <= hash_rd.pf;
                xas_reg <= hash_rd.ps;
            end
            S_Q_AE:
            begin
                xbf_reg <= hash_rd.pf;
                xbs_reg <= hash_rd.ps;
            end
            S_Q_BE:
            begin
                eaf_reg <= hash_rd.pf;
                eas_reg <= hash_rd.ps;
            end
            S_Q_MUL:
            begin
                cnt_reg <= '0;
                if (mdone[0])
                begin
                    res_reg <= '{equal: hm && req_reg.sub_len == '0,
                                 hash_match: hm, range_error: 1'b0};
                end
            end
            S_C_CHK:
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (ta_data != tb_data)
                begin
                    res_reg.equal <= 1'b0;
                end
                else if (cmp_last)
                begin
                    res_reg.equal <= 1'b1;
                end
            end
            default:
            begin
                cnt_reg <= cnt_reg;
            end
        endcase
        if (out_load)
        begin
            out_data_reg <= res_reg;
        end
    end

`ifndef SYNTH
    a_len_bound: assert property (@(posedge clk) disable iff (!rst_n)
        len_reg <= LEN_FULL)
        else $error("text length past capacity");

    a_done_in_mul: assert property (@(posedge clk) disable iff (!rst_n)
        mdone[0] |-> (state_reg == S_A_MUL || state_reg == S_Q_MUL))
        else $error("multiplier finished outside a multiply phase");

    a_err_clean: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.range_error |-> !out_data.equal && !out_data.hash_match)
        else $error("range error beat carries a match");

    a_eq_needs_hash: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.equal |-> out_data.hash_match)
        else $error("equal without hash match");

    a_write_once: assert property (@(posedge clk) disable iff (!rst_n)
        hash_we |=> !hash_we)
        else $error("table written on two cycles of one append");
`endif

endmodule

>>> bench/tb_top.sv
// self-checking testbench for the substring equality hash block
`timescale 1ns / 1ps

module tb_top;
    import seh_pkg::*;

    localparam int ITEMS_PER_PHASE = 18;

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              in_valid = 1'b0;
    logic              in_stall;
    in_item_t          in_data = '0;
    logic              out_valid;
    logic              out_stall = 1'b0;
    out_item_t         out_data;
    logic              cfg_valid = 1'b0;
    logic              cfg_ready;
    logic [HASH_W-1:0] cfg_data = '0;

    always #2 clk = ~clk;

    substring_equality_hash i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    // shadow copy of the text and the four hash tables
    logic [CHAR_W-1:0] text_chars [MAX_LEN];
    logic [HASH_W-1:0] pre_first  [MAX_LEN+1];
    logic [HASH_W-1:0] pre_second [MAX_LEN+1];
    logic [HASH_W-1:0] pow_first  [MAX_LEN+1];
    logic [HASH_W-1:0] pow_second [MAX_LEN+1];
    int                text_len;
    logic [HASH_W-1:0] cur_base;

    out_item_t pending_answers [$];

    // 0 none, 1 sender gaps, 2 receiver stalls, 3 both
    int idle_mode = 0;
    int fail_count = 0;
    int n_beats_in = 0;
    int n_answers = 0;
    int n_range = 0;
    int n_equal = 0;
    int n_hash_only = 0;

    function automatic logic [HASH_W-1:0] mul_add_mod(logic [HASH_W-1:0] x,
                                                      logic [HASH_W-1:0] y,
                                                      logic [HASH_W-1:0] add,
                                                      logic [HASH_W-1:0] m);
        longint unsigned v;
        v = longint'(x) * longint'(y) + longint'(add);
        return HASH_W'(v % longint'(m));
    endfunction

    function automatic logic [HASH_W-1:0] window_hash(bit second, int start, int len);
        logic [HASH_W-1:0] m;
        logic [HASH_W-1:0] t;
        longint unsigned   r;
        m = second ? MOD_SECOND : MOD_FIRST;
        if (second)
        begin
            t = mul_add_mod(pre_second[start], pow_second[len], '0, m);
            r = longint'(pre_second[start+len]) + longint'(m) - longint'(t);
        end
        else
        begin
            t = mul_add_mod(pre_first[start], pow_first[len], '0, m);
            r = longint'(pre_first[start+len]) + longint'(m) - longint'(t);
        end
        return HASH_W'(r % longint'(m));
    endfunction

    // advance the shadow state by one accepted request; returns 1 when an answer is due
    function automatic bit predict_request(in_item_t it, output out_item_t ans);
        int  a;
        int  b;
        int  len;
        bit  hm;
        bit  eq;
        ans = '0;
        a   = int'(it.pos_a);
        b   = int'(it.pos_b);
        len = int'(it.sub_len);
        case (it.req_type)
            REQ_APPEND:
            begin
                if (text_len < MAX_LEN)
                begin
                    text_chars[text_len]   = it.text_char;
                    pre_first[text_len+1]  = mul_add_mod(pre_first[text_len], cur_base,
                                                         HASH_W'(it.text_char), MOD_FIRST);
                    pre_second[text_len+1] = mul_add_mod(pre_second[text_len], cur_base,
                                                         HASH_W'(it.text_char), MOD_SECOND);
                    pow_first[text_len+1]  = mul_add_mod(pow_first[text_len], cur_base,
                                                         '0, MOD_FIRST);
                    pow_second[text_len+1] = mul_add_mod(pow_second[text_len], cur_base,
                                                         '0, MOD_SECOND);
                    text_len++;
                end
                return 1'b0;
            end
            REQ_CLEAR:
            begin
                text_len = 0;
                return 1'b0;
            end
            REQ_QUERY:
            begin
                if (a + len > text_len || b + len > text_len)
                begin
                    ans.range_error = 1'b1;
                    return 1'b1;
                end
                hm = window_hash(0, a, len) == window_hash(0, b, len) &&
                     window_hash(1, a, len) == window_hash(1, b, len);
                eq = hm;
                if (hm)
                begin
                    for (int i = 0; i < len; i++)
                    begin
                        if (text_chars[a+i] != text_chars[b+i])
                        begin
                            eq = 1'b0;
                        end
                    end
                end
                ans.equal      = eq;
                ans.hash_match = hm;
                return 1'b1;
            end
            default:
            begin
                return 1'b0;
            end
        endcase
    endfunction

    // sender: a gap lowers valid first; back-to-back beats keep valid high
    task automatic send_request(in_item_t it, bit fixed = 1'b0, out_item_t fixed_ans = '0);
        out_item_t ans;
        int        gap;
        gap = 0;
        if (idle_mode == 1 || idle_mode == 3)
        begin
            while ($urandom_range(99) < ((idle_mode == 1) ? 87 : 34) && gap < 60)
            begin
                gap++;
            end
        end
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= it;
        do
        begin
            @(posedge clk);
        end
        while (in_stall);
        n_beats_in++;
        if (predict_request(it, ans))
        begin
            pending_answers.push_back(fixed ? fixed_ans : ans);
        end
    endtask

    // hold off the sender until every answer is back and the block has gone quiet
    task automatic drain_block();
        in_valid <= 1'b0;
        while (pending_answers.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (64) @(posedge clk);
    endtask

    task automatic write_base(logic [HASH_W-1:0] value);
        drain_block();
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do
        begin
            @(posedge clk);
        end
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        cur_base = value;
    endtask

    function automatic in_item_t make_item(req_t req, int ch, int a, int b, int len);
        in_item_t it;
        it           = '0;
        it.req_type  = req;
        it.text_char = CHAR_W'(ch);
        it.pos_a     = POS_W'(a);
        it.pos_b     = POS_W'(b);
        it.sub_len   = LEN_W'(len);
        return it;
    endfunction

    // random request, mostly well-formed: text over a narrow alphabet and in-range windows
    function automatic in_item_t random_request();
        in_item_t    it;
        int          r;
        int          len;
        int          a;
        int          b;
        int          span;
        logic [63:0] raw;
        r = $urandom_range(99);
        if (text_len > 150 && $urandom_range(19) == 0)
        begin
            return make_item(REQ_CLEAR, $urandom_range(255), $urandom_range(1023),
                             $urandom_range(1023), $urandom_range(2047));
        end
        if (r < 45)
        begin
            if ($urandom_range(9) == 0)
            begin
                return make_item(REQ_APPEND, $urandom_range(255), $urandom_range(1023),
                                 $urandom_range(1023), $urandom_range(2047));
            end
            return make_item(REQ_APPEND, 8'h61 + $urandom_range(1), 0, 0, 0);
        end
        if (r < 86)
        begin
            span = (text_len < 12) ? text_len : 12;
            len  = ($urandom_range(15) == 0) ? $urandom_range(text_len)
                                             : $urandom_range(span);
            a    = $urandom_range(text_len - len);
            b    = ($urandom_range(3) == 0) ? a : $urandom_range(text_len - len);
            return make_item(REQ_QUERY, $urandom_range(255), a, b, len);
        end
        if (r < 89)
        begin
            return make_item(REQ_CLEAR, 0, 0, 0, 0);
        end
        raw = {$urandom, $urandom};
        it  = raw[$bits(in_item_t)-1:0];
        if (r < 93)
        begin
            it.req_type = REQ_NONE;
        end
        else
        begin
            it.req_type = REQ_QUERY;
        end
        return it;
    endfunction

    // receiver: check each accepted beat against the oldest expectation
    always @(posedge clk)
    begin
        out_item_t want;
        if (out_valid && !out_stall)
        begin
            if (pending_answers.size() == 0)
            begin
                $error("unexpected answer beat %b", out_data);
                fail_count++;
            end
            else
            begin
                want = pending_answers.pop_front();
                n_answers++;
                if (want.range_error)
                begin
                    n_range++;
                end
                if (want.equal)
                begin
                    n_equal++;
                end
                if (want.hash_match && !want.equal)
                begin
                    n_hash_only++;
                end
                if (out_data.equal !== want.equal)
                begin
                    $error("equal: expected %0d, got %0d", want.equal, out_data.equal);
                    fail_count++;
                end
                if (out_data.hash_match !== want.hash_match)
                begin
                    $error("hash_match: expected %0d, got %0d", want.hash_match,
                           out_data.hash_match);
                    fail_count++;
                end
                if (out_data.range_error !== want.range_error)
                begin
                    $error("range_error: expected %0d, got %0d", want.range_error,
                           out_data.range_error);
                    fail_count++;
                end
            end
        end
        if (idle_mode == 2)
        begin
            out_stall <= ($urandom_range(99) < 87);
        end
        else if (idle_mode == 3)
        begin
            out_stall <= ($urandom_range(99) < 34);
        end
        else
        begin
            out_stall <= 1'b0;
        end
    end

    typedef struct {
        in_item_t  it;
        bit        fixed;
        out_item_t ans;
    } directed_row_t;

    directed_row_t directed_rows [$];

    function automatic void add_row(in_item_t it, bit fixed = 1'b0, bit eq = 1'b0,
                                    bit hm = 1'b0, bit re = 1'b0);
        directed_row_t row;
        row.it  = it;
        row.fixed = fixed;
        row.ans = '{equal: eq, hash_match: hm, range_error: re};
        directed_rows.push_back(row);
    endfunction

    logic [HASH_W-1:0] phase_base [5];

    initial
    begin
        cur_base      = BASE_RESET;
        text_len      = 0;
        pre_first[0]  = '0;
        pre_second[0] = '0;
        pow_first[0]  = 1;
        pow_second[0] = 1;

        // empty text: zero length at zero is in range, past zero is not
        add_row(make_item(REQ_QUERY, 0, 0, 0, 0), 1, 1, 1, 0);
        add_row(make_item(REQ_QUERY, 0, 1, 0, 0), 1, 0, 0, 1);
        add_row(make_item(REQ_APPEND, 8'h61, 0, 0, 0));
        add_row(make_item(REQ_APPEND, 8'h62, 0, 0, 0));
        add_row(make_item(REQ_APPEND, 8'h61, 0, 0, 0));
        add_row(make_item(REQ_APPEND, 8'h62, 0, 0, 0));
        add_row(make_item(REQ_APPEND, 8'h00, 1023, 1023, 2047));
        add_row(make_item(REQ_APPEND, 8'hff, 0, 0, 0));
        add_row(make_item(REQ_QUERY, 0, 0, 2, 2));
        add_row(make_item(REQ_QUERY, 0, 0, 1, 2));
        add_row(make_item(REQ_QUERY, 0, 0, 0, 6));
        add_row(make_item(REQ_QUERY, 0, 4, 5, 1));
        add_row(make_item(REQ_QUERY, 8'hff, 1023, 0, 0), 1, 0, 0, 1);
        add_row(make_item(REQ_QUERY, 0, 0, 0, 1024), 1, 0, 0, 1);
        add_row(make_item(REQ_QUERY, 0, 0, 1023, 1), 1, 0, 0, 1);
        add_row(make_item(REQ_NONE, 8'h5a, 3, 3, 3));
        add_row(make_item(REQ_QUERY, 0, 6, 6, 0), 1, 1, 1, 0);
        add_row(make_item(REQ_CLEAR, 0, 0, 0, 0));
        add_row(make_item(REQ_QUERY, 0, 0, 0, 1), 1, 0, 0, 1);
        add_row(make_item(REQ_APPEND, 8'hff, 0, 0, 0));
        add_row(make_item(REQ_QUERY, 0, 0, 0, 1), 1, 1, 1, 0);
        add_row(make_item(REQ_CLEAR, 0, 0, 0, 0));

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[i])
        begin
            send_request(directed_rows[i].it, directed_rows[i].fixed, directed_rows[i].ans);
        end

        // fill to capacity with a periodic text, then push past it
        for (int i = 0; i < MAX_LEN + 6; i++)
        begin
            send_request(make_item(REQ_APPEND, (i % 7 == 6) ? 8'hff : 8'h30 + (i % 7),
                                   0, 0, 0));
        end
        send_request(make_item(REQ_QUERY, 0, 0, 0, 1024));
        send_request(make_item(REQ_QUERY, 0, 0, 7, 1017));
        send_request(make_item(REQ_QUERY, 0, 1023, 1016, 1));
        send_request(make_item(REQ_QUERY, 0, 1, 0, 1023));
        send_request(make_item(REQ_QUERY, 0, 0, 1, 1023));

        // base extremes; one phase keeps the old tables to mix bases
        phase_base[0] = 30'd2;
        phase_base[1] = 30'd1000000006;
        phase_base[2] = 30'h3fffffff;
        phase_base[3] = HASH_W'($urandom_range(1000000006, 2));
        phase_base[4] = BASE_RESET;
        for (int p = 0; p < 5; p++)
        begin
            write_base(phase_base[p]);
            idle_mode = p % 4;
            if (p != 2)
            begin
                send_request(make_item(REQ_CLEAR, 0, 0, 0, 0));
            end
            else
            begin
                send_request(make_item(REQ_QUERY, 0, 0, 7, 14));
            end
            for (int i = 0; i < ITEMS_PER_PHASE; i++)
            begin
                send_request(random_request());
            end
            if (p == 2)
            begin
                send_request(make_item(REQ_CLEAR, 0, 0, 0, 0));
            end
        end

        drain_block();
        repeat (64) @(posedge clk);
        $display("covered %0d request beats, %0d answers: %0d equal, %0d range errors,",
                 n_beats_in, n_answers, n_equal, n_range);
        $display("%0d hash-only matches, over five base settings and four idle patterns",
                 n_hash_only);
        if (fail_count == 0 && pending_answers.size() == 0)
        begin
            $display("PASS substring_equality_hash");
        end
        else
        begin
            $display("FAIL substring_equality_hash");
        end
        $finish;
    end

    // run limit, well above the slowest legal run
    initial
    begin
        #40_000_000;
        $display("FAIL substring_equality_hash");
        $finish;
    end

endmodule
